// ----- rtl/stlo_pkg.sv -----
// ----------------------------------------------------------------------------
// stlo_pkg
// Shared types and constants for the slot table with creation-order list.
// ----------------------------------------------------------------------------
package stlo_pkg;

    // Table geometry
    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int GEOM_W = 41;

    // Link value meaning "no slot"
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

    // Request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC_LINK,
        S_ALLOC_TAIL,
        S_FREE_PATCH
    } state_t;

    // Request transfer
    typedef struct packed {
        logic        cmd;
        logic [4:0]  slot;
        logic [63:0] vdev_size;
        logic [3:0]  mirror_count;
        logic [20:0] page_bytes;
        logic [15:0] primary_chunks;
    } req_t;

    // Result transfer
    typedef struct packed {
        status_t     status;
        logic [4:0]  result_slot;
        logic [5:0]  first_slot;
        logic [5:0]  last_slot;
        logic [5:0]  slot_count;
    } rsp_t;

endpackage

// ----- rtl/slot_table_with_linked_order.sv -----
// ----------------------------------------------------------------------------
// slot_table_with_linked_order
// Descriptor slot table: allocate takes the lowest free slot and appends it
// to a doubly linked creation-order list; free unlinks a named slot.
// ----------------------------------------------------------------------------
//  channel   | signals               | transfer when
//  ----------+-----------------------+------------------------------------
//  request   | start, busy, req      | start high and busy low at clk rise
//  result    | done, rsp             | done high (one cycle, no stall)
//
//  Allocate: busy in S_ALLOC_LINK, S_ALLOC_TAIL; result strobed next cycle.
//  Free: busy in S_FREE_PATCH; result strobed next cycle.
//  Errors (table full, slot not in use): busy stays low, result next cycle.
//  The step sequence is set by the link memories: one read and one write port
//  each, so the allocate needs two writes to the next-link memory.
//  Reset clears the in-use flags, head, tail and count; no clearing pass.
//  The result side cannot stall; a new request is taken while a result shows.
// ----------------------------------------------------------------------------
module slot_table_with_linked_order (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  stlo_pkg::req_t req,
    output logic           done,
    output stlo_pkg::rsp_t rsp
);
    import stlo_pkg::*;

    // Memories
    logic [LINK_W-1:0] prev_mem [SLOTS];
    logic [LINK_W-1:0] next_mem [SLOTS];
    logic [63:0]       size_mem [SLOTS];
    logic [GEOM_W-1:0] geom_mem [SLOTS];

    // Registers
    state_t            state_reg, state_next;
    logic [SLOTS-1:0]  in_use_reg, in_use_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    req_t              req_reg, req_next;
    rsp_t              rsp_reg, rsp_next;
    logic              done_reg, done_next;
    logic [LINK_W-1:0] prev_rd_reg, next_rd_reg;

    // Memory write ports
    logic              prev_we, next_we, desc_we;
    logic [SLOT_W-1:0] prev_wa, next_wa;
    logic [LINK_W-1:0] prev_wd, next_wd;
    logic [63:0]       size_wd;
    logic [GEOM_W-1:0] geom_wd;

    // Lowest free slot
    logic [SLOT_W-1:0] free_idx;
    logic              table_full;
    logic [LINK_W-1:0] cur_link;

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign table_full = &in_use_reg;
    assign cur_link   = {1'b0, cur_reg};

    // Sequencer: next state, list update and memory writes
    always_comb
    begin
        state_next  = state_reg;
        in_use_next = in_use_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        prev_we     = 1'b0;
        next_we     = 1'b0;
        desc_we     = 1'b0;
        prev_wa     = cur_reg;
        next_wa     = cur_reg;
        prev_wd     = tail_reg;
        next_wd     = NONE_LINK;
        size_wd     = req_reg.vdev_size;
        geom_wd     = {req_reg.mirror_count, req_reg.page_bytes, req_reg.primary_chunks};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        cur_next = free_idx;
                        if (table_full)
                        begin
                            done_next            = 1'b1;
                            rsp_next.status      = ST_FULL;
                            rsp_next.result_slot = '0;
                            rsp_next.first_slot  = head_reg;
                            rsp_next.last_slot   = tail_reg;
                            rsp_next.slot_count  = count_reg;
                        end
                        else
                        begin
                            state_next = S_ALLOC_LINK;
                        end
                    end
                    else
                    begin
                        cur_next = req.slot;
                        if (!in_use_reg[req.slot])
                        begin
                            done_next            = 1'b1;
                            rsp_next.status      = ST_NOT_ALLOC;
                            rsp_next.result_slot = '0;
                            rsp_next.first_slot  = head_reg;
                            rsp_next.last_slot   = tail_reg;
                            rsp_next.slot_count  = count_reg;
                        end
                        else
                        begin
                            state_next = S_FREE_PATCH;
                        end
                    end
                end
            end

            // new slot: back link to old tail, no successor, store descriptor
            S_ALLOC_LINK:
            begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                desc_we    = 1'b1;
                state_next = S_ALLOC_TAIL;
            end

            // old tail points forward to the new slot; flag and count together
            S_ALLOC_TAIL:
            begin
                if (tail_reg[SLOT_W])
                begin
                    head_next = cur_link;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = tail_reg[SLOT_W-1:0];
                    next_wd = cur_link;
                end
                in_use_next[cur_reg] = 1'b1;
                tail_next            = cur_link;
                count_next           = count_reg + LINK_W'(1);
                done_next            = 1'b1;
                rsp_next.status      = ST_OK;
                rsp_next.result_slot = cur_reg;
                rsp_next.first_slot  = head_next;
                rsp_next.last_slot   = tail_next;
                rsp_next.slot_count  = count_next;
                state_next           = S_IDLE;
            end

            // unlink: neighbours point past the freed slot
            S_FREE_PATCH:
            begin
                if (prev_rd_reg[SLOT_W])
                begin
                    head_next = next_rd_reg;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd_reg[SLOT_W-1:0];
                    next_wd = next_rd_reg;
                end
                if (next_rd_reg[SLOT_W])
                begin
                    tail_next = prev_rd_reg;
                end
                else
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd_reg[SLOT_W-1:0];
                    prev_wd = prev_rd_reg;
                end
                desc_we              = 1'b1;
                size_wd              = '0;
                geom_wd              = '0;
                in_use_next[cur_reg] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - LINK_W'(1);
                end
                done_next            = 1'b1;
                rsp_next.status      = ST_OK;
                rsp_next.result_slot = cur_reg;
                rsp_next.first_slot  = head_next;
                rsp_next.last_slot   = tail_next;
                rsp_next.slot_count  = count_next;
                state_next           = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
            head_reg   <= NONE_LINK;
            tail_reg   <= NONE_LINK;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Link and descriptor memories; links read at the requested slot
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (desc_we)
        begin
            size_mem[cur_reg] <= size_wd;
            geom_mem[cur_reg] <= geom_wd;
        end
        prev_rd_reg <= prev_mem[req.slot];
        next_rd_reg <= next_mem[req.slot];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // allocated slot count tracks the in-use flags
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_use_reg) == int'(count_reg))
        else $error("count does not match in-use flags");

    // empty list exactly when count is zero
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == NONE_LINK))
        else $error("head inconsistent with count");

    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (tail_reg == NONE_LINK))
        else $error("tail inconsistent with count");

    // a good result comes only from the final step of a request
    a_ok_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == ST_OK) |->
        ($past(state_reg) == S_ALLOC_TAIL || $past(state_reg) == S_FREE_PATCH))
        else $error("ok result without a finished request");

    // a free request is taken only for a slot in use
    a_free_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE_PATCH) |-> in_use_reg[cur_reg])
        else $error("freeing a slot that is not in use");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for slot_table_with_linked_order. A short scripted sequence walks
// the empty, single-entry, full and head/tail/middle free cases. Then several
// hundred random allocate and free requests drive the table between empty and
// full. A shadow copy of the in-use flags and list links predicts each result
// that lacks a scripted value; all are checked field by field on the strobe.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stlo_pkg::*;

    // How the descriptor fields of a scripted request are filled
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_MAX,
        FILL_RAND
    } fill_t;

    // One row of the scripted sequence
    typedef struct {
        logic       cmd;
        logic [4:0] slot;
        fill_t      fill;
        int         reps;
        bit         exact;
        rsp_t       rsp;
    } row_t;

    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL    = 100;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // Shadow of the table: in-use flags, links, head, tail and count
    logic              slot_taken [SLOTS];
    logic [LINK_W-1:0] link_prev  [SLOTS];
    logic [LINK_W-1:0] link_next  [SLOTS];
    logic [LINK_W-1:0] list_head;
    logic [LINK_W-1:0] list_tail;
    logic [5:0]        taken_cnt;

    rsp_t list_result_due [$];
    int   mismatch_cnt = 0;
    row_t script [$];

    slot_table_with_linked_order dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatch_cnt++;
        $display("%0t %s: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                 $realtime, what, want.status, want.result_slot, want.first_slot,
                 want.last_slot, want.slot_count, got.status, got.result_slot,
                 got.first_slot, got.last_slot, got.slot_count);
    endtask

    // Apply one request to the shadow table and work out its result
    function automatic void apply_to_table(input req_t r, output rsp_t o);
        int                s;
        int                i;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        o             = '0;
        o.status      = ST_OK;
        if (r.cmd == CMD_ALLOC)
        begin
            s = SLOTS;
            for (i = SLOTS - 1; i >= 0; i--)
                if (!slot_taken[i])
                    s = i;
            if (s == SLOTS)
                o.status = ST_FULL;
            else
            begin
                slot_taken[s] = 1'b1;
                link_prev[s]  = list_tail;
                if (list_tail != NONE_LINK)
                    link_next[list_tail[SLOT_W-1:0]] = LINK_W'(s);
                else
                    list_head = LINK_W'(s);
                link_next[s]  = NONE_LINK;
                list_tail     = LINK_W'(s);
                taken_cnt++;
                o.result_slot = SLOT_W'(s);
            end
        end
        else
        begin
            s = r.slot;
            if (!slot_taken[s])
                o.status = ST_NOT_ALLOC;
            else
            begin
                p = link_prev[s];
                n = link_next[s];
                if (p != NONE_LINK)
                    link_next[p[SLOT_W-1:0]] = n;
                else
                    list_head = n;
                if (n != NONE_LINK)
                    link_prev[n[SLOT_W-1:0]] = p;
                else
                    list_tail = p;
                slot_taken[s] = 1'b0;
                link_prev[s]  = '0;
                link_next[s]  = '0;
                if (taken_cnt != 0)
                    taken_cnt--;
                o.result_slot = r.slot;
            end
        end
        o.first_slot = list_head;
        o.last_slot  = list_tail;
        o.slot_count = taken_cnt;
    endfunction

    function automatic req_t desc_req(input logic cmd, input logic [4:0] slot, input fill_t fill);
        req_t r;
        r.cmd  = cmd;
        r.slot = slot;
        case (fill)
            FILL_ZERO:
            begin
                r.vdev_size      = '0;
                r.mirror_count   = '0;
                r.page_bytes     = '0;
                r.primary_chunks = '0;
            end
            FILL_MAX:
            begin
                r.vdev_size      = '1;
                r.mirror_count   = 4'd15;
                r.page_bytes     = 21'd1048576;
                r.primary_chunks = 16'hFFFF;
            end
            default:
            begin
                r.vdev_size      = {$urandom, $urandom};
                r.mirror_count   = 4'($urandom_range(0, 15));
                r.page_bytes     = 21'($urandom_range(0, 1048576));
                r.primary_chunks = 16'($urandom_range(0, 65535));
            end
        endcase
        return r;
    endfunction

    // Append one row to the scripted sequence
    function automatic void add_row(input logic cmd, input logic [4:0] slot, input fill_t fill,
                                    input int reps, input bit exact, input status_t st,
                                    input int rs, input int first, input int last,
                                    input int cnt);
        row_t w;
        w.cmd              = cmd;
        w.slot             = slot;
        w.fill             = fill;
        w.reps             = reps;
        w.exact            = exact;
        w.rsp.status       = st;
        w.rsp.result_slot  = 5'(rs);
        w.rsp.first_slot   = 6'(first);
        w.rsp.last_slot    = 6'(last);
        w.rsp.slot_count   = 6'(cnt);
        script.insert(script.size(), w);
    endfunction

    // Sender gap: none in calm stretches, else now and then an idle gap before a request
    function automatic int pick_gap(input bit calm);
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 10);
    endfunction

    // Present one request and hold it until the transfer; record what is due
    task automatic send(input req_t r, input bit exact, input rsp_t typed, input int gap);
        rsp_t pred;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_to_table(r, pred);
        list_result_due.insert(list_result_due.size(), exact ? typed : pred);
    endtask

    // Result check: each strobe is matched to the oldest outstanding request
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (list_result_due.size() == 0)
                report_mismatch("result with no request outstanding", '0, rsp);
            else
            begin
                want = list_result_due.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", want, rsp);
                else if (rsp.result_slot !== want.result_slot)
                    report_mismatch("result_slot", want, rsp);
                else if (rsp.first_slot !== want.first_slot)
                    report_mismatch("first_slot", want, rsp);
                else if (rsp.last_slot !== want.last_slot)
                    report_mismatch("last_slot", want, rsp);
                else if (rsp.slot_count !== want.slot_count)
                    report_mismatch("slot_count", want, rsp);
            end
        end
    end

    initial
    begin
        req_t       r;
        logic [4:0] pick;
        bit         filling;
        bit         quiet;
        int         roll;
        int         i;
        int         k;

        for (i = 0; i < SLOTS; i++)
        begin
            slot_taken[i] = 1'b0;
            link_prev[i]  = '0;
            link_next[i]  = '0;
        end
        list_head = NONE_LINK;
        list_tail = NONE_LINK;
        taken_cnt = '0;

        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted part: empty table, single entry, full table, head/tail/middle frees
        add_row(CMD_FREE,  5'd0,  FILL_ZERO, 1,  1, ST_NOT_ALLOC, 0,  32, 32, 0);
        add_row(CMD_ALLOC, 5'd0,  FILL_ZERO, 1,  1, ST_OK,        0,  0,  0,  1);
        add_row(CMD_FREE,  5'd0,  FILL_ZERO, 1,  1, ST_OK,        0,  32, 32, 0);
        add_row(CMD_FREE,  5'd0,  FILL_MAX,  1,  1, ST_NOT_ALLOC, 0,  32, 32, 0);
        add_row(CMD_ALLOC, 5'd31, FILL_MAX,  1,  1, ST_OK,        0,  0,  0,  1);
        add_row(CMD_ALLOC, 5'd0,  FILL_RAND, 31, 0, ST_OK,        0,  0,  0,  0);
        add_row(CMD_ALLOC, 5'd0,  FILL_RAND, 1,  1, ST_FULL,      0,  0,  31, 32);
        add_row(CMD_FREE,  5'd31, FILL_RAND, 1,  1, ST_OK,        31, 0,  30, 31);
        add_row(CMD_FREE,  5'd0,  FILL_RAND, 1,  1, ST_OK,        0,  1,  30, 30);
        add_row(CMD_FREE,  5'd16, FILL_RAND, 1,  0, ST_OK,        0,  0,  0,  0);
        add_row(CMD_FREE,  5'd16, FILL_RAND, 1,  1, ST_NOT_ALLOC, 0,  1,  30, 29);
        add_row(CMD_ALLOC, 5'd0,  FILL_MAX,  1,  0, ST_OK,        0,  0,  0,  0);
        add_row(CMD_ALLOC, 5'd0,  FILL_ZERO, 1,  0, ST_OK,        0,  0,  0,  0);
        add_row(CMD_ALLOC, 5'd0,  FILL_RAND, 1,  0, ST_OK,        0,  0,  0,  0);
        add_row(CMD_ALLOC, 5'd0,  FILL_RAND, 1,  1, ST_FULL,      0,  1,  31, 32);
        add_row(CMD_FREE,  5'd1,  FILL_RAND, 1,  0, ST_OK,        0,  0,  0,  0);

        foreach (script[j])
            for (k = 0; k < script[j].reps; k++)
                send(desc_req(script[j].cmd, script[j].slot, script[j].fill),
                     script[j].exact, script[j].rsp, pick_gap(1'b0));

        // Random part: sweep between empty and full; frees mostly name live slots
        filling = 1'b1;
        quiet   = 1'b0;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (taken_cnt == SLOTS)
                filling = 1'b0;
            else if (taken_cnt == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 79) == 0)
                filling = !filling;

            roll = $urandom_range(0, 99);
            if (filling ? (roll < 75) : (roll < 25))
                r = desc_req(CMD_ALLOC, 5'($urandom), FILL_RAND);
            else
            begin
                pick = 5'($urandom_range(0, 31));
                // Mostly a live slot; now and then any slot at all
                if ($urandom_range(0, 9) != 0 && taken_cnt != 0)
                    while (!slot_taken[pick])
                        pick = pick + 5'd1;
                r = desc_req(CMD_FREE, pick, FILL_RAND);
            end
            send(r, 1'b0, '0, pick_gap(quiet || k >= RANDOM_ITEMS - CALM_TAIL));
        end
        start <= 1'b0;

        // Drain outstanding results, then keep watching for stray strobes
        while (list_result_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/stlo_pkg.sv
rtl/slot_table_with_linked_order.sv
tb/tb_top.sv
